// File: sv/esbrx_pkg.sv
// Shared types, codes and defaults for the receiver ack/FIFO control block.
`timescale 1ns / 1ps
package esbrx_pkg;

   // Default sizes, handed down from the top level.
   localparam int RX_DEPTH_DEF    = 8;
   localparam int ACK_DEPTH_DEF   = 2;
   localparam int MAX_PAYLOAD_DEF = 32;

   // S1 field masks.
   localparam logic [2:0] S1_MASK  = 3'h7;
   localparam logic [1:0] PID_MASK = 2'h3;

   // Operation codes carried in the kind field.
   localparam logic [2:0] KIND_RADIO_END = 3'd0;
   localparam logic [2:0] KIND_ACK_QUEUE = 3'd1;
   localparam logic [2:0] KIND_TAKE_RX   = 3'd2;
   localparam logic [2:0] KIND_FLUSH_RX  = 3'd3;
   localparam logic [2:0] KIND_FLUSH_TX  = 3'd4;

   // Status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_PKT   = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_EMPTY     = 3'd3;
   localparam logic [2:0] STATUS_INVAL_LEN = 3'd4;

   // One request beat.
   typedef struct packed {
      logic [2:0]  kind;
      logic        crc_ok;
      logic [7:0]  length;
      logic [2:0]  control_bits;
      logic [15:0] packet_crc;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic [2:0] status;
      logic       tx_success;
      logic       rx_stored;
      logic       radio_rearm;
      logic       ack_start;
      logic [5:0] ack_length;
      logic [2:0] ack_control;
      logic [2:0] slot;
      logic [5:0] out_length;
      logic [1:0] out_pid;
      logic       out_noack;
      logic       duplicate;
   } rsp_type;

   // Receive metadata entry.
   typedef struct packed {
      logic [5:0] len;
      logic [1:0] pid;
      logic       noack;
   } rx_entry_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic lookup;
      logic execute;
   } ctrl_cmd_type;

endpackage

// File: sv/esbrx_ctrl.sv
// Sequencer: request/response handshakes and datapath step commands.
`timescale 1ns / 1ps
module esbrx_ctrl
   import esbrx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // Output register can take a new beat when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and commands.
   always_comb begin
      req_stall   = 1'b1;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
         end
         ST_EXEC: begin
            cmd.execute = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.execute) rsp_valid_in = 1'b1;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/esbrx_datapath.sv
// Datapath: FIFOs, duplicate filter, ack tracking and the response register.
`timescale 1ns / 1ps
module esbrx_datapath
   import esbrx_pkg::*;
#(
   parameter int RX_DEPTH    = RX_DEPTH_DEF,
   parameter int ACK_DEPTH   = ACK_DEPTH_DEF,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_data,
   input  logic         csr_write,
   input  logic         csr_data,
   input  ctrl_cmd_type cmd,
   output rsp_type      rsp_data
);

   localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int AAW = (ACK_DEPTH > 1) ? $clog2(ACK_DEPTH) : 1;
   localparam int RFW = $clog2(RX_DEPTH + 1);
   localparam int AFW = $clog2(ACK_DEPTH + 1);
   localparam logic [RAW-1:0] RX_LAST  = RAW'(RX_DEPTH - 1);
   localparam logic [AAW-1:0] ACK_LAST = AAW'(ACK_DEPTH - 1);
   localparam logic [RFW-1:0] RX_FULL  = RFW'(RX_DEPTH);
   localparam logic [AFW-1:0] ACK_FULL = AFW'(ACK_DEPTH);
   localparam logic [7:0]     MAX_LEN  = 8'(MAX_PAYLOAD);

   // Metadata memories.
   rx_entry_type rx_mem  [RX_DEPTH];
   logic [5:0]   ack_mem [ACK_DEPTH];

   // Registers.
   req_type        item_ff;
   rx_entry_type   rx_rd_ff;
   logic [5:0]     ack_rd_ff;
   rsp_type        rsp_ff, rsp_in;
   logic           rx_enable_ff;
   logic [RAW-1:0] rx_wr_ptr_ff, rx_wr_ptr_in;
   logic [RAW-1:0] rx_rd_ptr_ff, rx_rd_ptr_in;
   logic [RFW-1:0] rx_fill_ff, rx_fill_in;
   logic [AAW-1:0] ack_wr_ptr_ff, ack_wr_ptr_in;
   logic [AAW-1:0] ack_rd_ptr_ff, ack_rd_ptr_in;
   logic [AFW-1:0] ack_fill_ff, ack_fill_in;
   logic           transmitting_ff, transmitting_in;
   logic           ack_in_use_ff, ack_in_use_in;
   logic           last_valid_ff, last_valid_in;
   logic [1:0]     last_pid_ff, last_pid_in;
   logic [15:0]    last_crc_ff, last_crc_in;

   // Decode of the captured beat.
   logic           ack_req, dup, good_pkt, ack_pop, ack_in_use_next;
   logic [1:0]     pid;
   logic [AAW-1:0] ack_rd_next, ack_src;
   logic [AFW-1:0] ack_fill_pop;
   logic           rx_we, ack_we;
   rx_entry_type   rx_wr_entry;

   assign pid      = (item_ff.control_bits[2:1]) & PID_MASK;
   assign ack_req  = item_ff.control_bits[0];
   assign dup      = last_valid_ff && (last_pid_ff == pid) &&
                     (last_crc_ff == item_ff.packet_crc);
   assign good_pkt = item_ff.crc_ok && (item_ff.length <= MAX_LEN);

   // Ack head after releasing the payload that the previous ack carried.
   assign ack_pop         = ack_in_use_ff && !dup && (ack_fill_ff != '0);
   assign ack_rd_next     = (ack_rd_ptr_ff == ACK_LAST) ? '0 : ack_rd_ptr_ff + 1'b1;
   assign ack_src         = ack_pop ? ack_rd_next : ack_rd_ptr_ff;
   assign ack_fill_pop    = ack_pop ? ack_fill_ff - 1'b1 : ack_fill_ff;
   assign ack_in_use_next = (ack_fill_pop != '0);

   // Evaluate the beat against current state.
   always_comb begin
      rx_wr_ptr_in    = rx_wr_ptr_ff;
      rx_rd_ptr_in    = rx_rd_ptr_ff;
      rx_fill_in      = rx_fill_ff;
      ack_wr_ptr_in   = ack_wr_ptr_ff;
      ack_rd_ptr_in   = ack_rd_ptr_ff;
      ack_fill_in     = ack_fill_ff;
      transmitting_in = transmitting_ff;
      ack_in_use_in   = ack_in_use_ff;
      last_valid_in   = last_valid_ff;
      last_pid_in     = last_pid_ff;
      last_crc_in     = last_crc_ff;
      rx_we           = 1'b0;
      ack_we          = 1'b0;
      rx_wr_entry.len   = item_ff.length[5:0];
      rx_wr_entry.pid   = pid;
      rx_wr_entry.noack = !ack_req;
      rsp_in          = '0;
      case (item_ff.kind)
         KIND_RADIO_END: begin
            if (transmitting_ff) begin
               // End of our own ack transmission.
               transmitting_in    = 1'b0;
               rsp_in.tx_success  = 1'b1;
               rsp_in.radio_rearm = rx_enable_ff;
            end else if (good_pkt) begin
               last_valid_in = 1'b1;
               last_pid_in   = pid;
               last_crc_in   = item_ff.packet_crc;
               if (ack_req) begin
                  ack_rd_ptr_in      = ack_src;
                  ack_fill_in        = ack_fill_pop;
                  ack_in_use_in      = ack_in_use_next;
                  rsp_in.ack_length  = ack_in_use_next ? ack_rd_ff : 6'd0;
                  rsp_in.ack_control = item_ff.control_bits & S1_MASK;
                  rsp_in.slot        = 3'(ack_src);
                  rsp_in.ack_start   = 1'b1;
                  transmitting_in    = 1'b1;
               end
               if (!dup) begin
                  if (rx_fill_ff != RX_FULL) begin
                     rx_we              = 1'b1;
                     rx_wr_ptr_in       = (rx_wr_ptr_ff == RX_LAST) ? '0 :
                                          rx_wr_ptr_ff + 1'b1;
                     rx_fill_in         = rx_fill_ff + 1'b1;
                     rsp_in.rx_stored   = 1'b1;
                     rsp_in.slot        = 3'(rx_wr_ptr_ff);
                     rsp_in.out_length  = item_ff.length[5:0];
                     rsp_in.out_pid     = pid;
                     rsp_in.out_noack   = !ack_req;
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end
               rsp_in.duplicate   = dup;
               rsp_in.radio_rearm = rx_enable_ff && !ack_req;
            end else begin
               rsp_in.status      = STATUS_BAD_PKT;
               rsp_in.radio_rearm = rx_enable_ff;
            end
         end
         KIND_ACK_QUEUE: begin
            if ((item_ff.length == 8'd0) || (item_ff.length > MAX_LEN)) begin
               rsp_in.status = STATUS_INVAL_LEN;
            end else if (ack_fill_ff == ACK_FULL) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               ack_we        = 1'b1;
               ack_wr_ptr_in = (ack_wr_ptr_ff == ACK_LAST) ? '0 : ack_wr_ptr_ff + 1'b1;
               ack_fill_in   = ack_fill_ff + 1'b1;
               rsp_in.slot   = 3'(ack_wr_ptr_ff);
            end
         end
         KIND_TAKE_RX: begin
            if (rx_fill_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.slot       = 3'(rx_rd_ptr_ff);
               rsp_in.out_length = rx_rd_ff.len;
               rsp_in.out_pid    = rx_rd_ff.pid;
               rsp_in.out_noack  = rx_rd_ff.noack;
               rx_rd_ptr_in      = (rx_rd_ptr_ff == RX_LAST) ? '0 : rx_rd_ptr_ff + 1'b1;
               rx_fill_in        = rx_fill_ff - 1'b1;
            end
         end
         KIND_FLUSH_RX: begin
            rx_wr_ptr_in  = '0;
            rx_rd_ptr_in  = '0;
            rx_fill_in    = '0;
            last_valid_in = 1'b0;
         end
         KIND_FLUSH_TX: begin
            ack_wr_ptr_in = '0;
            ack_rd_ptr_in = '0;
            ack_fill_in   = '0;
            ack_in_use_in = 1'b0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Beat capture, memory reads and writes, response register.
   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      if (cmd.lookup) begin
         rx_rd_ff  <= rx_mem[rx_rd_ptr_ff];
         ack_rd_ff <= ack_mem[ack_src];
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
         if (rx_we)  rx_mem[rx_wr_ptr_ff]   <= rx_wr_entry;
         if (ack_we) ack_mem[ack_wr_ptr_ff] <= item_ff.length[5:0];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff    <= 1'b0;
         rx_wr_ptr_ff    <= '0;
         rx_rd_ptr_ff    <= '0;
         rx_fill_ff      <= '0;
         ack_wr_ptr_ff   <= '0;
         ack_rd_ptr_ff   <= '0;
         ack_fill_ff     <= '0;
         transmitting_ff <= 1'b0;
         ack_in_use_ff   <= 1'b0;
         last_valid_ff   <= 1'b0;
         last_pid_ff     <= '0;
         last_crc_ff     <= '0;
      end else begin
         if (csr_write) rx_enable_ff <= csr_data;
         if (cmd.execute) begin
            rx_wr_ptr_ff    <= rx_wr_ptr_in;
            rx_rd_ptr_ff    <= rx_rd_ptr_in;
            rx_fill_ff      <= rx_fill_in;
            ack_wr_ptr_ff   <= ack_wr_ptr_in;
            ack_rd_ptr_ff   <= ack_rd_ptr_in;
            ack_fill_ff     <= ack_fill_in;
            transmitting_ff <= transmitting_in;
            ack_in_use_ff   <= ack_in_use_in;
            last_valid_ff   <= last_valid_in;
            last_pid_ff     <= last_pid_in;
            last_crc_ff     <= last_crc_in;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: sv/esb_receiver_ack_fifo_control.sv
// A request beat passes capture, memory lookup and execute before its response beat is registered.
// A new request is taken only after the previous one has executed; the registered metadata memory read
// sits between capture and execute, and a waiting response stalls execute.
// A new request is taken while the previous response still waits in the output register.
// Reset (synchronous, active high) empties both FIFOs, clears the duplicate filter,
// ack state and rx_enable; memory contents are not cleared.
`timescale 1ns / 1ps
module esb_receiver_ack_fifo_control
   import esbrx_pkg::*;
#(
   parameter int RX_DEPTH    = RX_DEPTH_DEF,
   parameter int ACK_DEPTH   = ACK_DEPTH_DEF,
   parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   ctrl_cmd_type cmd;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   esbrx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   esbrx_datapath #(
      .RX_DEPTH    (RX_DEPTH),
      .ACK_DEPTH   (ACK_DEPTH),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .rsp_data  (rsp_data)
   );

endmodule

// File: verif/esb_receiver_ack_fifo_control_tb.sv
// Self-checking testbench for the receiver ack/FIFO control block.
`timescale 1ns / 1ps
module esb_receiver_ack_fifo_control_tb;
   import esbrx_pkg::*;

   localparam int RX_DEPTH    = RX_DEPTH_DEF;
   localparam int ACK_DEPTH   = ACK_DEPTH_DEF;
   localparam int MAX_PAYLOAD = MAX_PAYLOAD_DEF;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   esb_receiver_ack_fifo_control DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stimulus backlog, predicted responses, bookkeeping
   req_type req_backlog_q[$];
   rsp_type predicted_rsp_q[$];
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      error_count = 0;
   int      rsp_index = 0;
   int      quiet_cycles = 0;
   logic    req_taken = 1'b0;

   // Predictor state
   bit           rx_on;
   rx_entry_type rx_meta_mem [RX_DEPTH];
   int           rx_wr, rx_rd, rx_level;
   logic [5:0]   ack_len_mem [ACK_DEPTH];
   int           ack_wr, ack_rd, ack_count;
   bit           on_air, ack_loaded, filter_valid;
   logic [1:0]   filter_pid;
   logic [15:0]  filter_crc;

   // Generator memory of the last good packet, for retransmissions
   bit          sent_any = 1'b0;
   logic [1:0]  sent_pid;
   logic [15:0] sent_crc;

   // Expected response for one accepted request; updates predictor state.
   function automatic rsp_type predict_response(input req_type r);
      rsp_type    o;
      logic [1:0] pid;
      bit         ack_req, dup, started;
      o = '0;
      pid = r.control_bits[2:1];
      ack_req = r.control_bits[0];
      dup = 1'b0;
      started = 1'b0;
      case (r.kind)
         KIND_RADIO_END: begin
            if (on_air) begin
               // end of our own ack transmission
               on_air = 1'b0;
               o.tx_success = 1'b1;
               o.radio_rearm = rx_on;
            end else if (r.crc_ok && r.length <= MAX_PAYLOAD) begin
               dup = filter_valid && filter_pid == pid && filter_crc == r.packet_crc;
               filter_valid = 1'b1;
               filter_pid = pid;
               filter_crc = r.packet_crc;
               if (ack_req) begin
                  // previous ack payload was delivered unless this is a retry
                  if (ack_loaded && !dup && ack_count != 0) begin
                     ack_rd = (ack_rd + 1) % ACK_DEPTH;
                     ack_count--;
                  end
                  ack_loaded = ack_count != 0;
                  o.ack_length = ack_loaded ? ack_len_mem[ack_rd] : 6'd0;
                  o.ack_control = r.control_bits;
                  o.slot = 3'(ack_rd);
                  o.ack_start = 1'b1;
                  on_air = 1'b1;
                  started = 1'b1;
               end
               if (!dup) begin
                  if (rx_level < RX_DEPTH) begin
                     rx_meta_mem[rx_wr].len = r.length[5:0];
                     rx_meta_mem[rx_wr].pid = pid;
                     rx_meta_mem[rx_wr].noack = !ack_req;
                     o.rx_stored = 1'b1;
                     o.slot = 3'(rx_wr);
                     o.out_length = r.length[5:0];
                     o.out_pid = pid;
                     o.out_noack = !ack_req;
                     rx_wr = (rx_wr + 1) % RX_DEPTH;
                     rx_level++;
                  end else begin
                     o.status = STATUS_FULL;
                  end
               end
               o.duplicate = dup;
               o.radio_rearm = rx_on && !started;
            end else begin
               o.status = STATUS_BAD_PKT;
               o.radio_rearm = rx_on;
            end
         end
         KIND_ACK_QUEUE: begin
            if (r.length == 0 || r.length > MAX_PAYLOAD) begin
               o.status = STATUS_INVAL_LEN;
            end else if (ack_count >= ACK_DEPTH) begin
               o.status = STATUS_FULL;
            end else begin
               ack_len_mem[ack_wr] = r.length[5:0];
               o.slot = 3'(ack_wr);
               ack_wr = (ack_wr + 1) % ACK_DEPTH;
               ack_count++;
            end
         end
         KIND_TAKE_RX: begin
            if (rx_level == 0) begin
               o.status = STATUS_EMPTY;
            end else begin
               o.slot = 3'(rx_rd);
               o.out_length = rx_meta_mem[rx_rd].len;
               o.out_pid = rx_meta_mem[rx_rd].pid;
               o.out_noack = rx_meta_mem[rx_rd].noack;
               rx_rd = (rx_rd + 1) % RX_DEPTH;
               rx_level--;
            end
         end
         KIND_FLUSH_RX: begin
            rx_wr = 0;
            rx_rd = 0;
            rx_level = 0;
            filter_valid = 1'b0;
         end
         KIND_FLUSH_TX: begin
            ack_wr = 0;
            ack_rd = 0;
            ack_count = 0;
            ack_loaded = 1'b0;
         end
         default: ;  // unused kinds give an all-zero response
      endcase
      return o;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= 10)
            $display("[%0t] response %0d field %s: expected %0d, got %0d",
                     $time, rsp_index, name, want, got);
      end
   endtask

   task automatic queue_req(input int kind, input int crc_ok, input int len,
                            input int ctl, input int crc);
      req_type r;
      r.kind = 3'(kind);
      r.crc_ok = 1'(crc_ok);
      r.length = 8'(len);
      r.control_bits = 3'(ctl);
      r.packet_crc = 16'(crc);
      req_backlog_q.push_back(r);
   endtask

   // Request driver: new beat at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= req_backlog_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response backpressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Monitor: predict on request beats, check response beats
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall)
         predicted_rsp_q.push_back(predict_response(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("[%0t] unexpected response beat %h", $time, rsp_data);
         end else begin
            want = predicted_rsp_q.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("tx_success", 32'(want.tx_success), 32'(rsp_data.tx_success));
            check_field("rx_stored", 32'(want.rx_stored), 32'(rsp_data.rx_stored));
            check_field("radio_rearm", 32'(want.radio_rearm), 32'(rsp_data.radio_rearm));
            check_field("ack_start", 32'(want.ack_start), 32'(rsp_data.ack_start));
            check_field("ack_length", 32'(want.ack_length), 32'(rsp_data.ack_length));
            check_field("ack_control", 32'(want.ack_control), 32'(rsp_data.ack_control));
            check_field("slot", 32'(want.slot), 32'(rsp_data.slot));
            check_field("out_length", 32'(want.out_length), 32'(rsp_data.out_length));
            check_field("out_pid", 32'(want.out_pid), 32'(rsp_data.out_pid));
            check_field("out_noack", 32'(want.out_noack), 32'(rsp_data.out_noack));
            check_field("duplicate", 32'(want.duplicate), 32'(rsp_data.duplicate));
         end
         rsp_index++;
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_rx_enable(input bit value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      rx_on = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is in and every response is back
   task automatic wait_idle;
      while (req_backlog_q.size() != 0 || req_valid || predicted_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Random traffic: mostly well-formed exchanges, some noise
   task automatic queue_traffic(input int n);
      int count, pick, len, ctl, crc, kind;
      bit ack_req;
      count = 0;
      while (count < n) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            // good packet, new or retransmitted, acked exchanges closed by an end event
            ack_req = ($urandom_range(3) != 0);
            if (sent_any && $urandom_range(3) == 0) begin
               ctl = int'({sent_pid, ack_req});
               crc = sent_crc;
            end else begin
               ctl = int'({2'($urandom_range(3)), ack_req});
               crc = $urandom_range(16'hFFFF);
               sent_pid = 2'(ctl >> 1);
               sent_crc = 16'(crc);
               sent_any = 1'b1;
            end
            queue_req(KIND_RADIO_END, 1, $urandom_range(MAX_PAYLOAD), ctl, crc);
            count++;
            if (ack_req) begin
               queue_req(KIND_RADIO_END, $urandom_range(1), $urandom_range(255),
                         $urandom_range(7), $urandom_range(16'hFFFF));
               count++;
            end
         end else if (pick < 65) begin
            queue_req(KIND_TAKE_RX, $urandom_range(1), $urandom_range(255),
                      $urandom_range(7), $urandom_range(16'hFFFF));
            count++;
         end else if (pick < 80) begin
            len = ($urandom_range(9) != 0) ? $urandom_range(1, MAX_PAYLOAD)
                                            : $urandom_range(255);
            queue_req(KIND_ACK_QUEUE, $urandom_range(1), len,
                      $urandom_range(7), $urandom_range(16'hFFFF));
            count++;
         end else if (pick < 87) begin
            // rejected packet: bad CRC or oversize length byte
            if ($urandom_range(1))
               queue_req(KIND_RADIO_END, 0, $urandom_range(255),
                         $urandom_range(7), $urandom_range(16'hFFFF));
            else
               queue_req(KIND_RADIO_END, 1, $urandom_range(MAX_PAYLOAD + 1, 255),
                         $urandom_range(7), $urandom_range(16'hFFFF));
            count++;
         end else if (pick < 90) begin
            queue_req(KIND_FLUSH_RX, $urandom_range(1), $urandom_range(255),
                      $urandom_range(7), $urandom_range(16'hFFFF));
            count++;
         end else if (pick < 93) begin
            queue_req(KIND_FLUSH_TX, $urandom_range(1), $urandom_range(255),
                      $urandom_range(7), $urandom_range(16'hFFFF));
            count++;
         end else if (pick < 95) begin
            queue_req($urandom_range(5, 7), $urandom_range(1), $urandom_range(255),
                      $urandom_range(7), $urandom_range(16'hFFFF));
         end else begin
            kind = $urandom_range(7);
            queue_req(kind, $urandom_range(1), $urandom_range(255),
                      $urandom_range(7), $urandom_range(16'hFFFF));
            if (kind <= 4) count++;
         end
      end
   endtask

   initial begin
      rx_on = 1'b0;
      rx_wr = 0;
      rx_rd = 0;
      rx_level = 0;
      ack_wr = 0;
      ack_rd = 0;
      ack_count = 0;
      on_air = 1'b0;
      ack_loaded = 1'b0;
      filter_valid = 1'b0;
      filter_pid = '0;
      filter_crc = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      write_rx_enable(1'b1);
      send_idle_pct = 34;
      recv_idle_pct = 72;

      // Directed: status codes, FIFO limits, duplicates, ack flow
      queue_req(KIND_TAKE_RX, 0, 0, 0, 0);                 // take from empty
      queue_req(KIND_ACK_QUEUE, 1, 0, 0, 0);               // zero length ack
      queue_req(KIND_ACK_QUEUE, 1, MAX_PAYLOAD + 1, 0, 0); // oversize ack
      queue_req(KIND_ACK_QUEUE, 1, 255, 7, 16'hFFFF);
      queue_req(KIND_ACK_QUEUE, 0, 1, 0, 0);
      queue_req(KIND_ACK_QUEUE, 0, MAX_PAYLOAD, 0, 0);
      queue_req(KIND_ACK_QUEUE, 0, 7, 0, 0);               // ack queue full
      queue_req(KIND_RADIO_END, 0, 5, 1, 16'h1234);        // bad CRC
      queue_req(KIND_RADIO_END, 1, MAX_PAYLOAD + 1, 1, 16'h1234);
      queue_req(KIND_RADIO_END, 1, MAX_PAYLOAD, 3'b001, 16'hFFFF);
      queue_req(KIND_RADIO_END, 0, 0, 0, 0);               // ack sent
      queue_req(KIND_RADIO_END, 1, MAX_PAYLOAD, 3'b001, 16'hFFFF); // retransmission
      queue_req(KIND_RADIO_END, 0, 0, 0, 0);
      queue_req(KIND_RADIO_END, 1, 0, 3'b111, 16'h0000);   // new pid pops ack
      queue_req(KIND_FLUSH_TX, 0, 0, 0, 0);                // ack on air still ends
      queue_req(KIND_RADIO_END, 1, 255, 7, 16'hFFFF);
      for (int i = 0; i < 7; i++)                          // fill rx FIFO, then overflow
         queue_req(KIND_RADIO_END, 1, i + 1, (i % 4) << 1, 16'h1000 + i);
      queue_req(KIND_TAKE_RX, 1, 255, 7, 16'hFFFF);
      queue_req(KIND_FLUSH_RX, 0, 0, 0, 0);
      queue_req(5, 0, 0, 0, 0);
      queue_req(6, 1, 255, 7, 16'hFFFF);
      queue_req(7, 0, 0, 0, 0);
      wait_idle();

      write_rx_enable(1'b0);
      queue_traffic(200);
      wait_idle();

      send_idle_pct = 72;
      recv_idle_pct = 34;
      write_rx_enable(1'b1);
      queue_traffic(195);
      wait_idle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_rx_enable(1'b0);
      queue_traffic(195);
      wait_idle();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && predicted_rsp_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// File: filelist.f
sv/esbrx_pkg.sv
sv/esbrx_ctrl.sv
sv/esbrx_datapath.sv
sv/esb_receiver_ack_fifo_control.sv
verif/esb_receiver_ack_fifo_control_tb.sv
